// ----- src/set_assoc_cache_lru_fifo_lfu_assert.svh -----
// assertion macros for the cache tag store
`ifndef SET_ASSOC_CACHE_LRU_FIFO_LFU_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_FIFO_LFU_ASSERT_SVH
// implication checked on every clock, off during reset
`define SACL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked on the following clock
`define SACL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- src/sacl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and constants of the cache tag store
// ----------------------------------------------------------------------------
package sacl_pkg;
	localparam int unsigned NUM_SETS_DEF    = 64;
	localparam int unsigned NUM_WAYS_DEF    = 4;
	localparam int unsigned OFFSET_BITS_DEF = 5;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned AGE_W  = 32;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_INVAL = 2'd2,
		REQ_RSVD  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_RMISS = 2'd1,
		OUT_WMISS = 2'd2,
		OUT_INVAL = 2'd3
	} outcome_t;

	localparam logic [1:0] POL_LRU  = 2'd0;
	localparam logic [1:0] POL_FIFO = 2'd1;
	localparam logic [1:0] POL_LFU  = 2'd2;
endpackage

// ----- src/sacl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if / sacl_cfg_if
// valid/ready channels of the cache tag store
// ----------------------------------------------------------------------------
interface sacl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] access_address;
	logic        allocate_on_miss;
	modport source (output valid, req_type, access_address, allocate_on_miss, input ready);
	modport sink (input valid, req_type, access_address, allocate_on_miss, output ready);
endinterface

interface sacl_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic        evicted;
	logic [31:0] victim_address;
	logic        victim_dirty;
	logic        invalidated_present;
	logic        invalidated_dirty;
	modport source (output valid, outcome, evicted, victim_address, victim_dirty,
		invalidated_present, invalidated_dirty, input ready);
	modport sink (input valid, outcome, evicted, victim_address, victim_dirty,
		invalidated_present, invalidated_dirty, output ready);
endinterface

interface sacl_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- src/sacl_set_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_set_mem
// per-set line memory, one row per set, registered read
// ----------------------------------------------------------------------------
module sacl_set_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ----- src/set_assoc_cache_lru_fifo_lfu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_lfu
// write-back set-associative cache tag store with lru/fifo/lfu replacement
// ----------------------------------------------------------------------------
// usage:
//   req  : one transaction per access (read, write, invalidate, address,
//          allocate flag)
//   rsp  : one transaction per request (outcome, victim info, invalidate info)
//   cfg  : writes the replacement policy; write only while the block is idle
// order: the set row is read, then looked up and written back, then the
//   result goes to the output register.
// ordering: the single set memory is read then written back, so requests
//   are handled one at a time.
// reset: after arst_n rises a clearing pass writes zero to every set row,
//   during which req.ready stays low; cfg is taken always.
// stall: the response sits in an output register; while rsp.ready is low
//   the next request may still be taken and worked, and waits only
//   to publish its result until the register is free.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_fifo_lfu #(
	parameter int unsigned NUM_SETS    = sacl_pkg::NUM_SETS_DEF,
	parameter int unsigned NUM_WAYS    = sacl_pkg::NUM_WAYS_DEF,
	parameter int unsigned OFFSET_BITS = sacl_pkg::OFFSET_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sacl_req_if.sink   req,
	sacl_rsp_if.source rsp,
	sacl_cfg_if.sink   cfg
);
	localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int unsigned BLK_W  = sacl_pkg::ADDR_W - OFFSET_BITS;
	localparam int unsigned AGE_W  = sacl_pkg::AGE_W;
	// one line: valid, dirty, tag (block number), age
	localparam int unsigned LINE_W = 2 + BLK_W + AGE_W;
	// one row: all ways plus the set eviction count
	localparam int unsigned ROW_W  = NUM_WAYS * LINE_W + AGE_W;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [BLK_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} line_t;

	typedef struct packed {
		line_t [NUM_WAYS-1:0] ways;
		logic [AGE_W-1:0]     evict_cnt;
	} row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

	state_t            state_q;
	logic [SET_W:0]    clr_cnt_q;
	logic [1:0]        policy_q;
	logic [AGE_W-1:0]  seq_q;
	logic [1:0]        req_type_q;
	logic [BLK_W-1:0]  blk_q;
	logic              alloc_q;
	logic [SET_W-1:0]  set_q;
	logic              hold_q;   // result computed, waiting for output register

	// result register
	logic              rsp_valid_q;
	logic [1:0]        outcome_q;
	logic              evicted_q;
	logic [31:0]       vaddr_q;
	logic              vdirty_q;
	logic              ipres_q;
	logic              idirty_q;
	// pending result while output is stalled
	logic [1:0]        p_outcome_q;
	logic              p_evicted_q;
	logic [31:0]       p_vaddr_q;
	logic              p_vdirty_q;
	logic              p_ipres_q;
	logic              p_idirty_q;

	logic              mem_rd_en;
	logic [SET_W-1:0]  mem_rd_addr;
	logic [ROW_W-1:0]  mem_rd_data;
	logic              mem_wr_en;
	logic [SET_W-1:0]  mem_wr_addr;
	logic [ROW_W-1:0]  mem_wr_data;

	row_t              row_in;
	row_t              row_out;
	logic [AGE_W-1:0]  seq_nxt;
	logic [1:0]        c_outcome;
	logic              c_evicted;
	logic [31:0]       c_vaddr;
	logic              c_vdirty;
	logic              c_ipres;
	logic              c_idirty;

	logic req_fire;
	logic rsp_load;
	logic [SET_W-1:0] req_set;

	assign req.ready = (state_q == ST_IDLE) && !hold_q;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	// a finished result moves into the output register when it is free
	assign rsp_load  = (state_q == ST_WRITE || (state_q == ST_IDLE && hold_q))
		&& (!rsp_valid_q || rsp.ready);

	// set index: low bits of the block number (power-of-two set count)
	always_comb begin
		logic [BLK_W-1:0] b;
		b = req.access_address[sacl_pkg::ADDR_W-1:OFFSET_BITS];
		if (NUM_SETS > 1) begin
			req_set = b[SET_W-1:0];
		end else begin
			req_set = '0;
		end
	end

	assign mem_rd_en   = req_fire;
	assign mem_rd_addr = req_set;

	sacl_set_mem #(
		.DEPTH (NUM_SETS),
		.WIDTH (ROW_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	assign row_in = row_t'(mem_rd_data);

	// lookup, victim choice and row update for the request in ST_READ
	always_comb begin
		logic             hit;
		logic [WAY_W-1:0] hway;
		logic             inv_found;
		logic [WAY_W-1:0] pick;
		logic [AGE_W-1:0] best;
		logic             is_wr;
		logic             is_lfu;
		hit       = 1'b0;
		hway      = '0;
		inv_found = 1'b0;
		pick      = '0;
		best      = row_in.ways[0].age;
		is_wr     = (req_type_q == sacl_pkg::REQ_WRITE);
		is_lfu    = (policy_q == sacl_pkg::POL_LFU);
		row_out   = row_in;
		seq_nxt   = seq_q;
		c_outcome = sacl_pkg::OUT_HIT;
		c_evicted = 1'b0;
		c_vaddr   = '0;
		c_vdirty  = 1'b0;
		c_ipres   = 1'b0;
		c_idirty  = 1'b0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row_in.ways[w].valid && row_in.ways[w].tag == blk_q) begin
				hit  = 1'b1;
				hway = w[WAY_W-1:0];
			end
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (!row_in.ways[w].valid) begin
				inv_found = 1'b1;
				pick      = w[WAY_W-1:0];
			end
		end
		if (!inv_found) begin
			pick = '0;
			for (int w = 1; w < NUM_WAYS; w++) begin
				if (row_in.ways[w].age < best) begin
					best = row_in.ways[w].age;
					pick = w[WAY_W-1:0];
				end
			end
		end
		if (req_type_q == sacl_pkg::REQ_INVAL) begin
			c_outcome = sacl_pkg::OUT_INVAL;
			if (hit) begin
				c_ipres = 1'b1;
				c_idirty = row_in.ways[hway].dirty;
				row_out.ways[hway].valid = 1'b0;
				row_out.ways[hway].dirty = 1'b0;
			end
		end else if (hit) begin
			c_outcome = sacl_pkg::OUT_HIT;
			if (policy_q != sacl_pkg::POL_FIFO) begin
				if (is_lfu) begin
					row_out.ways[hway].age = row_in.ways[hway].age + 1'b1;
				end else begin
					seq_nxt = seq_q + 1'b1;
					row_out.ways[hway].age = seq_nxt;
				end
			end
			if (is_wr) begin
				row_out.ways[hway].dirty = 1'b1;
			end
		end else begin
			c_outcome = is_wr ? sacl_pkg::OUT_WMISS : sacl_pkg::OUT_RMISS;
			if (alloc_q) begin
				if (!inv_found) begin
					c_evicted = 1'b1;
					c_vaddr   = {row_in.ways[pick].tag, {OFFSET_BITS{1'b0}}};
					c_vdirty  = row_in.ways[pick].dirty;
					row_out.evict_cnt = row_in.ways[pick].age;
				end
				row_out.ways[pick].tag   = blk_q;
				row_out.ways[pick].valid = 1'b1;
				row_out.ways[pick].dirty = is_wr;
				if (is_lfu) begin
					row_out.ways[pick].age = row_out.evict_cnt + 1'b1;
				end else begin
					seq_nxt = seq_q + 1'b1;
					row_out.ways[pick].age = seq_nxt;
				end
			end
		end
	end

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = set_q;
		mem_wr_data = ROW_W'(row_out);
		if (state_q == ST_CLEAR) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = clr_cnt_q[SET_W-1:0];
			mem_wr_data = '0;
		end else if (state_q == ST_READ) begin
			mem_wr_en = 1'b1;
		end
	end

	// control, sequence number, policy register and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			policy_q    <= sacl_pkg::POL_LRU;
			seq_q       <= '0;
			hold_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				policy_q <= cfg.data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == (SET_W + 1)'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (rsp_load) begin
						hold_q <= 1'b0;
					end else if (req_fire) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					seq_q   <= seq_nxt;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
					if (!rsp_load) begin
						hold_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_type_q <= req.req_type;
			blk_q      <= req.access_address[sacl_pkg::ADDR_W-1:OFFSET_BITS];
			alloc_q    <= req.allocate_on_miss;
			set_q      <= req_set;
		end
		if (state_q == ST_READ) begin
			p_outcome_q <= c_outcome;
			p_evicted_q <= c_evicted;
			p_vaddr_q   <= c_vaddr;
			p_vdirty_q  <= c_vdirty;
			p_ipres_q   <= c_ipres;
			p_idirty_q  <= c_idirty;
		end
		if (rsp_load) begin
			outcome_q <= p_outcome_q;
			evicted_q <= p_evicted_q;
			vaddr_q   <= p_vaddr_q;
			vdirty_q  <= p_vdirty_q;
			ipres_q   <= p_ipres_q;
			idirty_q  <= p_idirty_q;
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.outcome             = outcome_q;
	assign rsp.evicted             = evicted_q;
	assign rsp.victim_address      = vaddr_q;
	assign rsp.victim_dirty        = vdirty_q;
	assign rsp.invalidated_present = ipres_q;
	assign rsp.invalidated_dirty   = idirty_q;
endmodule

// ----- src/sacl_checker.sv -----
`timescale 1ns / 1ps
`include "set_assoc_cache_lru_fifo_lfu_assert.svh"
// ----------------------------------------------------------------------------
// sacl_checker
// port-level checks of the cache tag store
// ----------------------------------------------------------------------------
module sacl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  outcome,
	input logic        evicted,
	input logic [31:0] victim_address,
	input logic        victim_dirty,
	input logic        invalidated_present,
	input logic        invalidated_dirty
);
	// a stalled response holds its outcome
	`SACL_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(outcome), "response dropped while stalled")
	// no victim fields without an eviction report
	`SACL_ASSERT_IMP(a_no_victim, clk, arst_n, rsp_valid && !evicted, victim_address == 32'd0 && !victim_dirty, "victim fields set without eviction")
	// invalidate info only on invalidate outcomes
	`SACL_ASSERT_IMP(a_inval_only, clk, arst_n, rsp_valid && outcome != sacl_pkg::OUT_INVAL, !invalidated_present && !invalidated_dirty, "invalidate flags on access")
	// accepted request is not followed by acceptance next cycle
	`SACL_ASSERT_NXT(a_one_at_time, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")
endmodule

bind set_assoc_cache_lru_fifo_lfu sacl_checker u_sacl_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.outcome             (rsp.outcome),
	.evicted             (rsp.evicted),
	.victim_address      (rsp.victim_address),
	.victim_dirty        (rsp.victim_dirty),
	.invalidated_present (rsp.invalidated_present),
	.invalidated_dirty   (rsp.invalidated_dirty)
);
